// ----- hdl/mtsg_pkg.sv -----
// ----------------------------------------------------------------------------
// mtsg_pkg
// Shared types, register codes and helpers for the max tile sum grid block.
// ----------------------------------------------------------------------------
package mtsg_pkg;

  // Configuration registers are all this wide
  localparam int unsigned REG_W   = 9;
  localparam int unsigned REG_MAX = (1 << REG_W) - 1;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned SUM_W   = 32;

  typedef logic [REG_W-1:0] reg_t;
  typedef logic [IDX_W-1:0] reg_idx_t;
  typedef logic [SUM_W-1:0] sum_t;

  // Register indexes
  localparam reg_idx_t REG_GRID_ROWS = 3'd0;
  localparam reg_idx_t REG_GRID_COLS = 3'd1;
  localparam reg_idx_t REG_TILE_ROWS = 3'd2;
  localparam reg_idx_t REG_TILE_COLS = 3'd3;

  // Per-cell control passed from the scan counters to the accumulator
  typedef struct packed {
    logic first;      // first cell of a tile: accumulator reads as zero
    logic accum;      // cell lies in a whole tile
    logic tile_done;  // last cell of its tile
    logic grid_done;  // last cell of the grid
  } cell_ctrl_t;

  // Zero acts as one, anything above the limit acts as the limit
  function automatic reg_t eff_size(input reg_t v, input reg_t lim);
    reg_t r;
    if (v == '0) begin
      r = reg_t'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- hdl/mtsg_scan.sv -----
// ----------------------------------------------------------------------------
// mtsg_scan
// Row/column position counters; classifies each incoming cell.
// ----------------------------------------------------------------------------
module mtsg_scan #(
  parameter int unsigned ADDR_W = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               accept,
  input  mtsg_pkg::reg_t     rows,
  input  mtsg_pkg::reg_t     cols,
  input  mtsg_pkg::reg_t     trows,
  input  mtsg_pkg::reg_t     tcols,
  output logic [ADDR_W-1:0]  addr,
  output mtsg_pkg::cell_ctrl_t ctrl
);
  import mtsg_pkg::*;

  reg_t row_pos;
  reg_t col_pos;
  reg_t row_in_tile;
  reg_t col_in_tile;
  reg_t row_base;
  reg_t col_base;
  logic [ADDR_W-1:0] tile_idx;

  logic row_last;
  logic col_last;
  logic row_in_last;
  logic col_in_last;
  logic row_whole;
  logic col_whole;

  // Position tests, one bit wider so that +1 cannot wrap
  assign row_last    = ({1'b0, row_pos} + 10'd1) >= {1'b0, rows};
  assign col_last    = ({1'b0, col_pos} + 10'd1) >= {1'b0, cols};
  assign row_in_last = ({1'b0, row_in_tile} + 10'd1) >= {1'b0, trows};
  assign col_in_last = ({1'b0, col_in_tile} + 10'd1) >= {1'b0, tcols};

  // A tile is whole when it ends inside the grid
  assign row_whole = ({1'b0, row_base} + {1'b0, trows}) <= {1'b0, rows};
  assign col_whole = ({1'b0, col_base} + {1'b0, tcols}) <= {1'b0, cols};

  assign addr           = tile_idx;
  assign ctrl.first     = (row_in_tile == '0) && (col_in_tile == '0);
  assign ctrl.accum     = row_whole && col_whole;
  assign ctrl.tile_done = row_in_last && col_in_last;
  assign ctrl.grid_done = row_last && col_last;

  // Counter update per accepted cell
  always_ff @(posedge clk) begin
    if (rst || clear || (accept && row_last && col_last)) begin
      row_pos     <= '0;
      col_pos     <= '0;
      row_in_tile <= '0;
      col_in_tile <= '0;
      row_base    <= '0;
      col_base    <= '0;
      tile_idx    <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_pos     <= '0;
        col_in_tile <= '0;
        col_base    <= '0;
        tile_idx    <= '0;
        row_pos     <= row_pos + reg_t'(1);
        if (row_in_last) begin
          row_in_tile <= '0;
          row_base    <= row_pos + reg_t'(1);
        end else begin
          row_in_tile <= row_in_tile + reg_t'(1);
        end
      end else begin
        col_pos <= col_pos + reg_t'(1);
        if (col_in_last) begin
          col_in_tile <= '0;
          col_base    <= col_pos + reg_t'(1);
          tile_idx    <= tile_idx + ADDR_W'(1);
        end else begin
          col_in_tile <= col_in_tile + reg_t'(1);
        end
      end
    end
  end

endmodule

// ----- hdl/mtsg_accum.sv -----
// ----------------------------------------------------------------------------
// mtsg_accum
// Per-tile-column accumulator memory, best-sum tracking and result register.
// ----------------------------------------------------------------------------
module mtsg_accum #(
  parameter int unsigned ADDR_W     = 8,
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] cell_data,
  input  logic [ADDR_W-1:0]     addr,
  input  mtsg_pkg::cell_ctrl_t  ctrl,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mtsg_pkg::sum_t        out_sum
);
  import mtsg_pkg::*;

  sum_t acc_mem [DEPTH];

  // Stage register
  logic                  s1_valid;
  logic [VALUE_BITS-1:0] s1_cell;
  logic [ADDR_W-1:0]     s1_addr;
  cell_ctrl_t            s1_ctrl;
  sum_t                  rd_data;
  logic                  fwd_hit;
  sum_t                  fwd_data;
  sum_t                  best_sum;

  logic                  accept;
  logic                  advance;
  sum_t                  acc_old;
  logic [SUM_W:0]        sum_wide;
  sum_t                  sum_sat;
  sum_t                  wr_data;
  sum_t                  best_next;

  // Stage holds only while a grid result waits for a full output register
  assign advance  = s1_valid && !(s1_ctrl.grid_done && out_valid && !out_ready);
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  // Accumulate with bypass of the write made in the accept cycle
  assign acc_old   = s1_ctrl.first ? '0 : (fwd_hit ? fwd_data : rd_data);
  assign sum_wide  = {1'b0, acc_old} + (SUM_W + 1)'(s1_cell);
  assign sum_sat   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
  assign wr_data   = s1_ctrl.tile_done ? '0 : sum_sat;
  assign best_next = (s1_ctrl.accum && s1_ctrl.tile_done && (sum_sat > best_sum)) ?
                     sum_sat : best_sum;

  // Memory and payload registers
  always_ff @(posedge clk) begin
    if (advance && s1_ctrl.accum) begin
      acc_mem[s1_addr] <= wr_data;
    end
    if (accept) begin
      rd_data  <= acc_mem[addr];
      fwd_data <= wr_data;
      s1_cell  <= cell_data;
      s1_addr  <= addr;
      s1_ctrl  <= ctrl;
    end
    if (advance && s1_ctrl.grid_done) begin
      out_sum <= best_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_hit   <= 1'b0;
      best_sum  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= advance && s1_ctrl.accum && (s1_addr == addr);
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (clear) begin
        best_sum <= '0;
      end else if (advance) begin
        best_sum <= s1_ctrl.grid_done ? '0 : best_next;
      end

      if (advance && s1_ctrl.grid_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Only a finished grid may hold the stage
  a_stall_only_on_result: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_ctrl.grid_done |-> advance)
    else $error("stage stalled on a cell that ends no grid");

  // Best sum restarts after each grid
  a_best_cleared: assert property (@(posedge clk) disable iff (rst)
    advance && s1_ctrl.grid_done |=> best_sum == '0)
    else $error("best sum not cleared after grid result");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(advance && s1_ctrl.grid_done))
    else $error("result register overwritten while full");

  // Result register loads exactly when a grid ends
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    advance && s1_ctrl.grid_done |=> out_valid && out_sum == $past(best_next))
    else $error("grid result not presented");

endmodule

// ----- hdl/max_tile_sum_grid.sv -----
// ----------------------------------------------------------------------------
// max_tile_sum_grid
// Streams grid cells in row-major order, sums whole non-overlapping tiles and
// returns the largest tile sum after the last cell of each grid.
//
//   Channel  Signals                                   Direction
//   ------   ----------------------------------------  ---------
//   input    in_valid, in_ready, cell_value            in
//   result   out_valid, out_ready, max_tile_sum        out
//   config   cfg_write, cfg_index, cfg_data            in
//
// One cell is taken per clock while the input is not stalled; a cell's
// accumulate and compare run in the stage after its input register, with
// a one-entry bypass on the tile column memory so back-to-back cells of one
// tile need no bubble. The result is loaded when the last cell leaves the stage.
// Input stalls only while a grid result waits in a full result register.
// Reset (synchronous) loads the default sizes and clears all counters;
// the memory needs no clearing pass, a tile's first cell reads it as zero.
// ----------------------------------------------------------------------------
module max_tile_sum_grid #(
  parameter int unsigned MAX_GRID   = 256,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  mtsg_pkg::reg_idx_t     cfg_index,
  input  mtsg_pkg::reg_t         cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_BITS-1:0]  cell_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mtsg_pkg::sum_t         max_tile_sum
);
  import mtsg_pkg::*;

  localparam int unsigned ADDR_W   = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int unsigned SIZE_LIM = (MAX_GRID > REG_MAX) ? REG_MAX : MAX_GRID;
  localparam reg_t        LIM      = reg_t'(SIZE_LIM);

  reg_t grid_rows;
  reg_t grid_cols;
  reg_t tile_rows;
  reg_t tile_cols;

  reg_t rows;
  reg_t cols;
  reg_t trows;
  reg_t tcols;

  logic              cfg_hit;
  logic              accept;
  logic [ADDR_W-1:0] addr;
  cell_ctrl_t        ctrl;

  // Register decode; a write to a listed register restarts the grid
  always_comb begin
    unique case (cfg_index) inside
      REG_GRID_ROWS, REG_GRID_COLS, REG_TILE_ROWS, REG_TILE_COLS: cfg_hit = cfg_write;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= reg_t'(8);
      grid_cols <= reg_t'(8);
      tile_rows <= reg_t'(2);
      tile_cols <= reg_t'(2);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_ROWS: grid_rows <= cfg_data;
        REG_GRID_COLS: grid_cols <= cfg_data;
        REG_TILE_ROWS: tile_rows <= cfg_data;
        REG_TILE_COLS: tile_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes
  assign rows  = eff_size(grid_rows, LIM);
  assign cols  = eff_size(grid_cols, LIM);
  assign trows = eff_size(tile_rows, LIM);
  assign tcols = eff_size(tile_cols, LIM);

  assign accept = in_valid && in_ready;

  mtsg_scan #(
    .ADDR_W (ADDR_W)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .clear  (cfg_hit),
    .accept (accept),
    .rows   (rows),
    .cols   (cols),
    .trows  (trows),
    .tcols  (tcols),
    .addr   (addr),
    .ctrl   (ctrl)
  );

  mtsg_accum #(
    .ADDR_W     (ADDR_W),
    .DEPTH      (MAX_GRID),
    .VALUE_BITS (VALUE_BITS)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_hit),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cell_data (cell_value),
    .addr      (addr),
    .ctrl      (ctrl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_sum   (max_tile_sum)
  );

endmodule
